// ===== design/cfsa_pkg.sv =====
package cfsa_pkg;

	localparam int MAX_SECTORS_DEF        = 1024;
	localparam int MAX_RECORD_SECTORS_DEF = 64;
	localparam int SURFACES               = 2;

	// register field widths
	localparam int PC_W  = 4;
	localparam int TPS_W = 11;
	localparam int SPT_W = 11;
	localparam int CAP_W = 13;
	localparam int LEN_W = 16;

	// derived geometry widths
	localparam int PSURF_W = TPS_W + SPT_W;
	localparam int PPLAT_W = PSURF_W + 1;
	localparam int PROD_W  = PPLAT_W + PC_W;
	localparam int LIM_W   = CAP_W + 7;

	// result field widths
	localparam int STATUS_W = 2;
	localparam int SIDX_W   = 10;
	localparam int PLAT_W   = 3;
	localparam int TRK_W    = 10;
	localparam int SIT_W    = 10;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 48;
	localparam int M_TUSER_W = 3;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_PLATTER_COUNT      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACKS_PER_SURFACE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_TRACK  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_CAPACITY    = 8'd3;

	localparam logic [PC_W-1:0]  PC_RST  = 4'd1;
	localparam logic [TPS_W-1:0] TPS_RST = 11'd16;
	localparam logic [SPT_W-1:0] SPT_RST = 11'd32;
	localparam logic [CAP_W-1:0] CAP_RST = 13'd512;

	localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

	typedef struct packed {
		logic [PC_W-1:0]  platter_count;
		logic [TPS_W-1:0] tracks_per_surface;
		logic [SPT_W-1:0] sectors_per_track;
		logic [CAP_W-1:0] sector_capacity;
	} geom_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SIDX_W-1:0]   sector_index;
		logic [PLAT_W-1:0]   platter_no;
		logic                surface_no;
		logic [TRK_W-1:0]    track_no;
		logic [SIT_W-1:0]    sector_in_track;
		logic [CAP_W-1:0]    piece_bytes;
		logic                continuation;
		logic                last_piece;
	} res_t;

endpackage

// ===== design/cfsa_cfg.sv =====
module cfsa_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cfsa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cfsa_pkg::CFG_DATA_W-1:0]    cfg_data,
	output cfsa_pkg::geom_t                    geom
);
	import cfsa_pkg::*;

	geom_t geom_q;

	assign cfg_ready = 1'b1;
	assign geom      = geom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.platter_count      <= PC_RST;
			geom_q.tracks_per_surface <= TPS_RST;
			geom_q.sectors_per_track  <= SPT_RST;
			geom_q.sector_capacity    <= CAP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PLATTER_COUNT:      geom_q.platter_count      <= cfg_data[PC_W-1:0];
				REG_TRACKS_PER_SURFACE: geom_q.tracks_per_surface <= cfg_data[TPS_W-1:0];
				REG_SECTORS_PER_TRACK:  geom_q.sectors_per_track  <= cfg_data[SPT_W-1:0];
				REG_SECTOR_CAPACITY:    geom_q.sector_capacity    <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/cfsa_div.sv =====
module cfsa_div #(
	parameter int NW = 10,
	parameter int DW = 23
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient,
	output logic [DW-1:0] remainder
);
	import cfsa_pkg::*;

	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;

	logic [DW:0]   trial;
	logic          q_bit;
	logic [DW:0]   diff;
	logic [NW:0]   quo_shift;

	always_comb begin
		trial     = {rem_q, quo_q[NW-1]};
		q_bit     = trial >= {1'b0, dsr_q};
		diff      = trial - {1'b0, dsr_q};
		quo_shift = {quo_q, q_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// one quotient bit a cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= quo_shift[NW-1:0];
			rem_q <= q_bit ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== design/chained_free_sector_allocator_core.sv =====
// channel   direction  handshake         content
// s         in         s_tvalid/tready   s_tdata[15:0] record_length
// m         out        m_tvalid/tready   m_tdata address and piece bytes, m_tuser status
//                                        and continuation, m_tlast last piece of record
// cfg       in         cfg_valid/ready   cfg_index register, cfg_data value
//
// An empty or too-long record is answered from the check state. Otherwise two
// passes of the shared bit-serial divider split the first free index into
// platter, surface, track and sector, and then one piece goes out per cycle
// while m is not stalled. Sectors are handed out in index order and never freed,
// so a fill count after reset stands for the whole free map; no clearing pass is
// needed. A stalled m holds the sequencer at the next result.
module chained_free_sector_allocator_core #(
	parameter int MAX_SECTORS        = cfsa_pkg::MAX_SECTORS_DEF,
	parameter int MAX_RECORD_SECTORS = cfsa_pkg::MAX_RECORD_SECTORS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [cfsa_pkg::S_TDATA_W-1:0]   s_tdata,  // [15:0] record_length
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [9:0] sector_index, [12:10] platter_no, [13] surface_no, [23:14] track_no,
	// [33:24] sector_in_track, [46:34] piece_bytes, [47] zero
	output logic [cfsa_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [cfsa_pkg::M_TUSER_W-1:0]   m_tuser,  // [1:0] status, [2] continuation
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cfsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cfsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cfsa_pkg::*;

	localparam int IW    = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
	localparam int CNT_W = IW + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_TOTAL = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_DIV1  = 3'd4;
	localparam logic [2:0] ST_DIV2  = 3'd5;
	localparam logic [2:0] ST_PIECE = 3'd6;
	localparam logic [2:0] ST_FULL  = 3'd7;

	geom_t geom;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  fill_q;
	logic              m_tvalid_q;
	res_t              res_q;

	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   rem_q;
	logic               cont_q;
	logic [CNT_W-1:0]   total_q;
	logic [PSURF_W-1:0] per_surf_q;
	logic [PC_W-1:0]    plat_q;
	logic               surf_q;
	logic [TPS_W-1:0]   trk_q;
	logic [SPT_W-1:0]   sec_q;

	logic               div_start;
	logic [IW-1:0]      div_dividend;
	logic [PPLAT_W-1:0] div_divisor;
	logic               div_done;
	logic [IW-1:0]      div_quo;
	logic [PPLAT_W-1:0] div_rem;

	logic [CAP_W-1:0]   cap_eff;
	logic [LIM_W-1:0]   limit;
	logic               too_long;
	logic [PPLAT_W-1:0] per_plat;
	logic [PROD_W-1:0]  prod;
	logic [CNT_W-1:0]   total_d;
	logic [CAP_W-1:0]   piece;
	logic               piece_last;
	logic               out_free;
	logic               emit;
	res_t               res_d;
	logic               surf_hi;
	logic [PPLAT_W-1:0] r2;
	logic [CNT_W-1:0]   fill_nx;
	logic               sec_wrap;
	logic               trk_wrap;

	cfsa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	cfsa_div #(
		.NW (IW),
		.DW (PPLAT_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cap_eff    = (geom.sector_capacity == '0) ? CAP_W'(1) : geom.sector_capacity;
		limit      = LIM_W'(cap_eff) * LIM_W'(MAX_RECORD_SECTORS);
		too_long   = LIM_W'(len_q) > limit;
		per_plat   = {per_surf_q, 1'b0};
		prod       = PROD_W'(per_plat) * PROD_W'(geom.platter_count);
		total_d    = (prod > PROD_W'(MAX_SECTORS)) ? CNT_W'(MAX_SECTORS) : prod[CNT_W-1:0];
		piece      = (rem_q > LEN_W'(cap_eff)) ? cap_eff : rem_q[CAP_W-1:0];
		piece_last = rem_q <= LEN_W'(cap_eff);
		surf_hi    = div_rem >= PPLAT_W'(per_surf_q);
		r2         = surf_hi ? (div_rem - PPLAT_W'(per_surf_q)) : div_rem;
		fill_nx    = fill_q + CNT_W'(1);
		sec_wrap   = ({1'b0, sec_q} + (SPT_W + 1)'(1)) == {1'b0, geom.sectors_per_track};
		trk_wrap   = ({1'b0, trk_q} + (TPS_W + 1)'(1)) == {1'b0, geom.tracks_per_surface};
	end

	// divider: first index over sectors per platter, then the rest over sectors per track
	always_comb begin
		div_start    = 1'b0;
		div_dividend = fill_q[IW-1:0];
		div_divisor  = per_plat;
		if (state_q == ST_START && fill_q < total_q) begin
			div_start = 1'b1;
		end else if (state_q == ST_DIV1 && div_done) begin
			div_start    = 1'b1;
			div_dividend = r2[IW-1:0];
			div_divisor  = PPLAT_W'(geom.sectors_per_track);
		end
	end

	always_comb begin
		emit  = 1'b0;
		res_d = '0;
		res_d.last_piece = 1'b1;
		unique case (state_q)
			ST_CHECK: begin
				if (len_q == '0) begin
					emit         = out_free;
					res_d.status = ST_EMPTY;
				end else if (too_long) begin
					emit         = out_free;
					res_d.status = ST_TOO_LONG;
				end
			end
			ST_PIECE: begin
				emit                  = out_free;
				res_d.status          = ST_PLACED;
				res_d.sector_index    = SIDX_W'(fill_q);
				res_d.platter_no      = PLAT_W'(plat_q);
				res_d.surface_no      = surf_q;
				res_d.track_no        = TRK_W'(trk_q);
				res_d.sector_in_track = SIT_W'(sec_q);
				res_d.piece_bytes     = piece;
				res_d.continuation    = cont_q;
				res_d.last_piece      = piece_last;
			end
			ST_FULL: begin
				emit         = out_free;
				res_d.status = ST_NO_FREE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (len_q == '0 || too_long) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_TOTAL;
					end
				end
				ST_TOTAL: state_q <= ST_START;
				ST_START: state_q <= (fill_q < total_q) ? ST_DIV1 : ST_FULL;
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_PIECE;
					end
				end
				ST_PIECE: begin
					if (out_free) begin
						fill_q <= fill_nx;
						if (piece_last) begin
							state_q <= ST_IDLE;
						end else if (fill_nx >= total_q) begin
							state_q <= ST_FULL;
						end
					end
				end
				ST_FULL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
		if (s_tvalid && s_tready) begin
			len_q  <= s_tdata[LEN_W-1:0];
			rem_q  <= s_tdata[LEN_W-1:0];
			cont_q <= 1'b0;
		end
		if (state_q == ST_CHECK) begin
			per_surf_q <= PSURF_W'(geom.tracks_per_surface) * PSURF_W'(geom.sectors_per_track);
		end
		if (state_q == ST_TOTAL) begin
			total_q <= total_d;
		end
		if (state_q == ST_DIV1 && div_done) begin
			plat_q <= PC_W'(div_quo);
			surf_q <= surf_hi;
		end
		if (state_q == ST_DIV2 && div_done) begin
			trk_q <= TPS_W'(div_quo);
			sec_q <= SPT_W'(div_rem);
		end
		// advance the address to the next index
		if (state_q == ST_PIECE && out_free) begin
			rem_q  <= rem_q - LEN_W'(piece);
			cont_q <= 1'b1;
			if (sec_wrap) begin
				sec_q <= '0;
				if (trk_wrap) begin
					trk_q  <= '0;
					surf_q <= !surf_q;
					if (surf_q) begin
						plat_q <= plat_q + PC_W'(1);
					end
				end else begin
					trk_q <= trk_q + TPS_W'(1);
				end
			end else begin
				sec_q <= sec_q + SPT_W'(1);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, res_q.piece_bytes, res_q.sector_in_track, res_q.track_no,
		res_q.surface_no, res_q.platter_no, res_q.sector_index};
	assign m_tuser  = {res_q.continuation, res_q.status};
	assign m_tlast  = res_q.last_piece;

endmodule
